### hw/rtl/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg
// shared types and constants of the x-frame motor mixer pipeline
// ----------------------------------------------------------------------------
package qxmm_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned DriveW    = 12;   // motor drive, throttle, config limits
  localparam int unsigned CtrlW     = 12;   // signed controller terms
  localparam int unsigned YawBaseW  = 10;
  localparam int unsigned LimW      = 12;   // yaw_base_limit + |yaw_command| <= 3071
  localparam int unsigned MixW      = 15;   // mixed sum spans -6144 .. 10239
  localparam int unsigned DesatW    = 16;   // sum minus excess
  localparam int unsigned CfgIdxW   = 8;

  // motor order: rear right, front right, rear left, front left
  // a set bit means the term is subtracted for that motor
  localparam logic [NumMotors-1:0] RollNeg  = 4'b0011;
  localparam logic [NumMotors-1:0] PitchNeg = 4'b1010;
  localparam logic [NumMotors-1:0] YawNeg   = 4'b0110;

  localparam int unsigned MotorRearRight  = 0;
  localparam int unsigned MotorFrontRight = 1;
  localparam int unsigned MotorRearLeft   = 2;
  localparam int unsigned MotorFrontLeft  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OUTPUT_MIN     = 8'd0,
    CFG_OUTPUT_MAX     = 8'd1,
    CFG_STOP_OUTPUT    = 8'd2,
    CFG_YAW_BASE_LIMIT = 8'd3
  } cfg_idx_e;

  localparam logic [DriveW-1:0]   OutputMinRst    = 12'd1150;
  localparam logic [DriveW-1:0]   OutputMaxRst    = 12'd1850;
  localparam logic [DriveW-1:0]   StopOutputRst   = 12'd1000;
  localparam logic [YawBaseW-1:0] YawBaseLimitRst = 10'd100;

  typedef logic signed [MixW-1:0] mix_t;

  typedef struct packed {
    logic [DriveW-1:0]   output_min;
    logic [DriveW-1:0]   output_max;
    logic [DriveW-1:0]   stop_output;
    logic [YawBaseW-1:0] yaw_base_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [CtrlW-1:0] pid_roll;
    logic signed [CtrlW-1:0] pid_pitch;
    logic signed [CtrlW-1:0] pid_yaw;
    logic [DriveW-1:0]       throttle;
    logic signed [CtrlW-1:0] yaw_command;
    logic                    armed;
    logic                    stop_request;
  } in_t;

  typedef struct packed {
    logic [DriveW-1:0] motor_rear_right;
    logic [DriveW-1:0] motor_front_right;
    logic [DriveW-1:0] motor_rear_left;
    logic [DriveW-1:0] motor_front_left;
    logic              stopped;
  } out_t;

  // after yaw clamp
  typedef struct packed {
    logic signed [CtrlW-1:0] roll;
    logic signed [CtrlW-1:0] pitch;
    logic signed [CtrlW-1:0] yaw;
    logic [DriveW-1:0]       thr;
    logic                    stopped;
  } yaw_t;

  // after mixing
  typedef struct packed {
    mix_t [NumMotors-1:0] motor;
    logic                 stopped;
  } mixed_t;

  // after max search
  typedef struct packed {
    mix_t [NumMotors-1:0] motor;
    logic [MixW-1:0]      excess;
    logic                 stopped;
  } limit_t;

endpackage

### hw/rtl/qxmm_yaw_stage.sv
// ----------------------------------------------------------------------------
// qxmm_yaw_stage
// first pipeline stage: yaw clamp against base limit widened by |yaw command|
// ----------------------------------------------------------------------------
module qxmm_yaw_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [qxmm_pkg::YawBaseW-1:0]       yaw_base_limit_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  qxmm_pkg::in_t                       data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output qxmm_pkg::yaw_t                      data_o
);

  logic [qxmm_pkg::LimW-1:0]      cmd_abs;
  logic [qxmm_pkg::LimW-1:0]      lim;
  logic signed [qxmm_pkg::LimW:0] lim_pos;
  logic signed [qxmm_pkg::LimW:0] lim_neg;
  logic signed [qxmm_pkg::LimW:0] yaw_ext;
  logic signed [qxmm_pkg::CtrlW-1:0] yaw_clamped;
  qxmm_pkg::yaw_t                 data_d, data_q;
  logic                           valid_q;

  always_comb begin
    // -(-2048) lands on 2048 as an unsigned 12 bit value
    cmd_abs = data_i.yaw_command[qxmm_pkg::CtrlW-1] ?
              (~data_i.yaw_command + 1'b1) : data_i.yaw_command;
    lim     = {{(qxmm_pkg::LimW-qxmm_pkg::YawBaseW){1'b0}}, yaw_base_limit_i} + cmd_abs;
    lim_pos = $signed({1'b0, lim});
    lim_neg = -lim_pos;
    yaw_ext = {data_i.pid_yaw[qxmm_pkg::CtrlW-1], data_i.pid_yaw};
    // the chosen bound is always reachable from the yaw input, so it fits 12 bits
    if (yaw_ext < lim_neg) begin
      yaw_clamped = lim_neg[qxmm_pkg::CtrlW-1:0];
    end else if (yaw_ext > lim_pos) begin
      yaw_clamped = lim_pos[qxmm_pkg::CtrlW-1:0];
    end else begin
      yaw_clamped = data_i.pid_yaw;
    end
    data_d.roll    = data_i.pid_roll;
    data_d.pitch   = data_i.pid_pitch;
    data_d.yaw     = yaw_clamped;
    data_d.thr     = data_i.throttle;
    data_d.stopped = !data_i.armed || data_i.stop_request;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/qxmm_mix_stage.sv
// ----------------------------------------------------------------------------
// qxmm_mix_stage
// second pipeline stage: throttle plus signed roll, pitch and yaw per motor
// ----------------------------------------------------------------------------
module qxmm_mix_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qxmm_pkg::yaw_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qxmm_pkg::mixed_t  data_o
);

  localparam int unsigned ExtW = qxmm_pkg::MixW - qxmm_pkg::CtrlW;

  qxmm_pkg::mix_t   roll_p, pitch_p, yaw_p, thr_e;
  qxmm_pkg::mixed_t data_d, data_q;
  logic             valid_q;

  always_comb begin
    roll_p  = {{ExtW{data_i.roll[qxmm_pkg::CtrlW-1]}}, data_i.roll};
    pitch_p = {{ExtW{data_i.pitch[qxmm_pkg::CtrlW-1]}}, data_i.pitch};
    yaw_p   = {{ExtW{data_i.yaw[qxmm_pkg::CtrlW-1]}}, data_i.yaw};
    thr_e   = {{(qxmm_pkg::MixW-qxmm_pkg::DriveW){1'b0}}, data_i.thr};
    for (int i = 0; i < qxmm_pkg::NumMotors; i++) begin
      data_d.motor[i] = thr_e
                      + (qxmm_pkg::RollNeg[i]  ? -roll_p  : roll_p)
                      + (qxmm_pkg::PitchNeg[i] ? -pitch_p : pitch_p)
                      + (qxmm_pkg::YawNeg[i]   ? -yaw_p   : yaw_p);
    end
    data_d.stopped = data_i.stopped;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/qxmm_limit_stage.sv
// ----------------------------------------------------------------------------
// qxmm_limit_stage
// third pipeline stage: largest motor value and its excess over output_max
// ----------------------------------------------------------------------------
module qxmm_limit_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [qxmm_pkg::DriveW-1:0]    output_max_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  qxmm_pkg::mixed_t               data_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output qxmm_pkg::limit_t               data_o
);

  qxmm_pkg::mix_t   max01, max23, max_all, hi_e, diff;
  qxmm_pkg::limit_t data_d, data_q;
  logic             valid_q;

  always_comb begin
    max01   = ($signed(data_i.motor[1]) > $signed(data_i.motor[0])) ?
              data_i.motor[1] : data_i.motor[0];
    max23   = ($signed(data_i.motor[3]) > $signed(data_i.motor[2])) ?
              data_i.motor[3] : data_i.motor[2];
    max_all = (max23 > max01) ? max23 : max01;
    hi_e    = $signed({{(qxmm_pkg::MixW-qxmm_pkg::DriveW){1'b0}}, output_max_i});
    diff    = max_all - hi_e;
    data_d.motor   = data_i.motor;
    // excess is positive and below 10240 when taken
    data_d.excess  = (max_all > hi_e) ? diff : '0;
    data_d.stopped = data_i.stopped;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/qxmm_clamp_stage.sv
// ----------------------------------------------------------------------------
// qxmm_clamp_stage
// last pipeline stage: excess shift, min/max clamp and stop override
// ----------------------------------------------------------------------------
module qxmm_clamp_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qxmm_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  qxmm_pkg::limit_t   data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output qxmm_pkg::out_t     data_o
);

  localparam int unsigned PadW = qxmm_pkg::DesatW - qxmm_pkg::DriveW;

  logic signed [qxmm_pkg::DesatW-1:0] lo_e, hi_e, excess_e;
  logic signed [qxmm_pkg::DesatW-1:0] shifted [qxmm_pkg::NumMotors];
  logic [qxmm_pkg::DriveW-1:0]        drive [qxmm_pkg::NumMotors];
  qxmm_pkg::out_t                     data_d, data_q;
  logic                               valid_q;

  always_comb begin
    lo_e     = $signed({{PadW{1'b0}}, cfg_i.output_min});
    hi_e     = $signed({{PadW{1'b0}}, cfg_i.output_max});
    excess_e = $signed({1'b0, data_i.excess});
    for (int i = 0; i < qxmm_pkg::NumMotors; i++) begin
      shifted[i] = {data_i.motor[i][qxmm_pkg::MixW-1], data_i.motor[i]} - excess_e;
      // low bound checked first, so output_min wins when limits cross
      if (data_i.stopped) begin
        drive[i] = cfg_i.stop_output;
      end else if (shifted[i] < lo_e) begin
        drive[i] = cfg_i.output_min;
      end else if (shifted[i] > hi_e) begin
        drive[i] = cfg_i.output_max;
      end else begin
        drive[i] = shifted[i][qxmm_pkg::DriveW-1:0];
      end
    end
    data_d.motor_rear_right  = drive[qxmm_pkg::MotorRearRight];
    data_d.motor_front_right = drive[qxmm_pkg::MotorFrontRight];
    data_d.motor_rear_left   = drive[qxmm_pkg::MotorRearLeft];
    data_d.motor_front_left  = drive[qxmm_pkg::MotorFrontLeft];
    data_d.stopped           = data_i.stopped;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/quad_x_motor_mixer.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// x-frame quadcopter motor mixer, four stage pipeline with config registers
// ----------------------------------------------------------------------------
// usage
// - input channel: in_valid_i / in_stall_o with in_data_i; a request is taken
//   at a rising edge with valid high and stall low
// - output channel: out_valid_o / out_stall_i with out_data_o; every input
//   request gives exactly one output request with four motor drives
// - config channel: cfg_valid_i / cfg_ready_o, cfg_index_i picks output_min,
//   output_max, stop_output or yaw_base_limit; unknown indexes are dropped;
//   write only while the pipeline is empty
// - pipeline: a taken request passes one stage register each for yaw clamp,
//   mixing, max search and excess shift with clamp, and leaves from the last
// - throughput: one request per cycle while out_stall_i is low, set by the
//   four stage registers; each stage holds one request and refills as soon
//   as it drains
// - stall: out_stall_i freezes the output register; stages behind it keep
//   filling bubbles, in_stall_o rises only once all four stages are full
// - reset: all stages empty, config registers back to their defaults
// ----------------------------------------------------------------------------
module quad_x_motor_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  qxmm_pkg::in_t                       in_data_i,
  // output requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output qxmm_pkg::out_t                      out_data_o,
  // config writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qxmm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [qxmm_pkg::DriveW-1:0]         cfg_data_i
);

  qxmm_pkg::cfg_t   cfg_q;

  logic             yaw_ready, yaw_valid;
  logic             mix_ready, mix_valid;
  logic             lim_ready, lim_valid;
  logic             clp_ready;
  qxmm_pkg::yaw_t   yaw_data;
  qxmm_pkg::mixed_t mix_data;
  qxmm_pkg::limit_t lim_data;

  // config register file, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_min     <= qxmm_pkg::OutputMinRst;
      cfg_q.output_max     <= qxmm_pkg::OutputMaxRst;
      cfg_q.stop_output    <= qxmm_pkg::StopOutputRst;
      cfg_q.yaw_base_limit <= qxmm_pkg::YawBaseLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qxmm_pkg::CFG_OUTPUT_MIN: begin
          cfg_q.output_min <= cfg_data_i;
        end
        qxmm_pkg::CFG_OUTPUT_MAX: begin
          cfg_q.output_max <= cfg_data_i;
        end
        qxmm_pkg::CFG_STOP_OUTPUT: begin
          cfg_q.stop_output <= cfg_data_i;
        end
        qxmm_pkg::CFG_YAW_BASE_LIMIT: begin
          cfg_q.yaw_base_limit <= cfg_data_i[qxmm_pkg::YawBaseW-1:0];
        end
        default: begin
          // writes past the register list are ignored
        end
      endcase
    end
  end

  // stall toward the sender whenever the first stage cannot take a request
  assign in_stall_o = !yaw_ready;

  // stage 1: yaw clamp, stop decision
  qxmm_yaw_stage u_yaw (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .yaw_base_limit_i (cfg_q.yaw_base_limit),
    .valid_i          (in_valid_i),
    .ready_o          (yaw_ready),
    .data_i           (in_data_i),
    .valid_o          (yaw_valid),
    .ready_i          (mix_ready),
    .data_o           (yaw_data)
  );

  // stage 2: four signed sums
  qxmm_mix_stage u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (yaw_valid),
    .ready_o (mix_ready),
    .data_i  (yaw_data),
    .valid_o (mix_valid),
    .ready_i (lim_ready),
    .data_o  (mix_data)
  );

  // stage 3: max over motors, excess above output_max
  qxmm_limit_stage u_limit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .output_max_i (cfg_q.output_max),
    .valid_i      (mix_valid),
    .ready_o      (lim_ready),
    .data_i       (mix_data),
    .valid_o      (lim_valid),
    .ready_i      (clp_ready),
    .data_o       (lim_data)
  );

  // stage 4: shift, clamp, stop override; its register is the output register
  qxmm_clamp_stage u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (lim_valid),
    .ready_o (clp_ready),
    .data_i  (lim_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // the input side only backs up once the whole pipeline is full and stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && yaw_valid && mix_valid && lim_valid))
    else $error("input stalled while the pipeline has room");

  // a stopped result carries the stop value on every motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stopped) |->
      (out_data_o.motor_rear_right  == cfg_q.stop_output &&
       out_data_o.motor_front_right == cfg_q.stop_output &&
       out_data_o.motor_rear_left   == cfg_q.stop_output &&
       out_data_o.motor_front_left  == cfg_q.stop_output))
    else $error("stopped result without stop value");

  // a running result never exceeds output_max unless it was clamped to output_min
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.stopped) |->
      ((out_data_o.motor_rear_right  <= cfg_q.output_max ||
        out_data_o.motor_rear_right  == cfg_q.output_min) &&
       (out_data_o.motor_front_right <= cfg_q.output_max ||
        out_data_o.motor_front_right == cfg_q.output_min) &&
       (out_data_o.motor_rear_left   <= cfg_q.output_max ||
        out_data_o.motor_rear_left   == cfg_q.output_min) &&
       (out_data_o.motor_front_left  <= cfg_q.output_max ||
        out_data_o.motor_front_left  == cfg_q.output_min)))
    else $error("motor drive above output_max");
`endif

endmodule
